[hdl/mbx_pkg.sv]
// ----------------------------------------------------------------------------
// mbx_pkg
// Shared types and constants of the dual-processor mailbox: command codes,
// control word bits and masks, and the request and response item layouts.
// ----------------------------------------------------------------------------
package mbx_pkg;

    // Access commands
    typedef enum logic [1:0] {
        CMD_SEND  = 2'd0,
        CMD_RECV  = 2'd1,
        CMD_CTRL  = 2'd2,
        CMD_NONE  = 2'd3
    } mbx_cmd_t;

    // Control word bits
    localparam int unsigned CTL_SEND_EMPTY   = 0;
    localparam int unsigned CTL_SEND_FULL    = 1;
    localparam int unsigned CTL_SEND_IRQ_EN  = 2;
    localparam int unsigned CTL_RECV_EMPTY   = 8;
    localparam int unsigned CTL_RECV_FULL    = 9;
    localparam int unsigned CTL_RECV_IRQ_EN  = 10;
    localparam int unsigned CTL_ERROR        = 14;
    localparam int unsigned CTL_ENABLE       = 15;

    // Control word masks
    localparam logic [15:0] CTL_RESET_VAL    = 16'h0101;
    localparam logic [15:0] MASK_SEND_SIDE   = 16'hBFFC; // drop send flags and error
    localparam logic [15:0] MASK_RECV_SIDE   = 16'hBCFF; // drop receive flags and error
    localparam logic [15:0] MASK_CLEAR_REQ   = 16'h4008; // clear request or error ack
    localparam logic [15:0] MASK_KEEP_WRITER = 16'h0301;
    localparam logic [15:0] MASK_TAKE_VALUE  = 16'h8404;
    localparam logic [15:0] MASK_KEEP_PEER   = 16'h8407;

    // Interrupt kinds
    typedef enum logic {
        IRQ_SEND_EMPTY = 1'b0,
        IRQ_RECV_READY = 1'b1
    } mbx_irq_kind_t;

    // Request item
    typedef struct packed {
        logic [1:0]  command;
        logic        side;
        logic [31:0] write_data;
    } mbx_req_t;

    // Response item
    typedef struct packed {
        logic [31:0] read_data;
        logic [15:0] control_side0;
        logic [15:0] control_side1;
        logic        irq_fire;
        logic        irq_side;
        logic        irq_kind;
    } mbx_rsp_t;

endpackage

[hdl/mbx_if.sv]
// ----------------------------------------------------------------------------
// mbx_req_if / mbx_rsp_if
// Valid/ready channels that carry mailbox requests and responses.
// ----------------------------------------------------------------------------
interface mbx_req_if;
    import mbx_pkg::*;

    logic     valid;
    logic     ready;
    mbx_req_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface mbx_rsp_if;
    import mbx_pkg::*;

    logic     valid;
    logic     ready;
    mbx_rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[hdl/mbx_ram.sv]
// ----------------------------------------------------------------------------
// mbx_ram
// Simple dual-port word memory: one write port, one read port with
// registered read data that holds while the read enable is low.
// ----------------------------------------------------------------------------
module mbx_ram #(
    parameter int unsigned ADDR_W = 5,
    parameter int unsigned DATA_W = 32
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [2**ADDR_W];
    logic [DATA_W-1:0] rd_data_reg;

    // Store one word
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Fetch one word
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hdl/dual_cpu_mailbox_fifo.sv]
// ----------------------------------------------------------------------------
// dual_cpu_mailbox_fifo
// Two-sided 32-bit mailbox with one send FIFO and one control word per side.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one bus access per item: command (send, receive, control
//   write), the issuing side and the write data. rsp returns one item per
//   request: the received word, both control words after the access and an
//   interrupt pulse (fire, target side, kind).
//   The result is registered: it is in the response register in the cycle
//   after the request is taken. Throughput is one item per cycle; the single
//   response register sets it, so req.ready is high while that register is
//   empty or being taken in the same cycle.
//   The FIFO words live in one memory of 2 x 2^PTR_W words,
//   one write and one registered read per cycle; pointers, fill counts and
//   control words are flip-flops updated in the same cycle.
//   Reset empties both FIFOs and sets each control word to 0x0101 (send and
//   receive empty, disabled); no clearing pass is needed, and the block takes
//   items from the first cycle after reset.
//   When the receiver stalls rsp, the response holds and req.ready drops
//   until it is taken; no state changes meanwhile.
// ----------------------------------------------------------------------------
module dual_cpu_mailbox_fifo #(
    parameter int unsigned FIFO_DEPTH = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    mbx_req_if.sink         req,
    mbx_rsp_if.source       rsp
);
    import mbx_pkg::*;

    localparam int unsigned PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FIFO_DEPTH);

    typedef struct packed {
        logic [PTR_W-1:0] rp;
        logic [PTR_W-1:0] wp;
        logic [CNT_W-1:0] cnt;
    } fifo_state_t;

    // State registers
    fifo_state_t  fifo0_reg, fifo1_reg, fifo0_next, fifo1_next;
    logic [15:0]  ctrl0_reg, ctrl1_reg, ctrl0_next, ctrl1_next;
    logic         rsp_valid_reg;
    logic         rd_ok_reg, rd_ok_next;
    logic         irq_fire_reg, irq_fire_next;
    logic         irq_side_reg, irq_side_next;
    logic         irq_kind_reg, irq_kind_next;

    // Per-access working values
    logic         accept;
    logic         me;
    logic         other;
    mbx_cmd_t     cmd;
    logic [15:0]  cl, cr, cl_next, cr_next, cval;
    fifo_state_t  f_me, f_other, f_me_next, f_other_next;
    logic         wr_en;
    logic         rd_en;
    logic [31:0]  ram_q;

    assign accept  = req.valid && req.ready;
    assign req.ready = !rsp_valid_reg || rsp.ready;

    assign me      = req.data.side;
    assign other   = ~req.data.side;
    assign cmd     = mbx_cmd_t'(req.data.command);
    assign cval    = req.data.write_data[15:0];
    assign cl      = me ? ctrl1_reg : ctrl0_reg;
    assign cr      = me ? ctrl0_reg : ctrl1_reg;
    assign f_me    = me ? fifo1_reg : fifo0_reg;
    assign f_other = me ? fifo0_reg : fifo1_reg;

    // Decode one access
    always_comb
    begin
        cl_next       = cl;
        cr_next       = cr;
        f_me_next     = f_me;
        f_other_next  = f_other;
        wr_en         = 1'b0;
        rd_ok_next    = 1'b0;
        irq_fire_next = 1'b0;
        irq_side_next = 1'b0;
        irq_kind_next = IRQ_SEND_EMPTY;
        case (cmd)
            CMD_SEND:
            begin
                if (cl[CTL_ENABLE])
                begin
                    if (f_me.cnt == CNT_FULL)
                    begin
                        cl_next[CTL_ERROR] = 1'b1;
                    end
                    else
                    begin
                        wr_en         = 1'b1;
                        f_me_next.wp  = (f_me.wp == PTR_LAST) ? '0 : f_me.wp + 1'b1;
                        f_me_next.cnt = f_me.cnt + 1'b1;
                        cl_next       = cl & MASK_SEND_SIDE;
                        cr_next       = cr & MASK_RECV_SIDE;
                        if (f_me_next.cnt == CNT_FULL)
                        begin
                            cl_next[CTL_SEND_FULL] = 1'b1;
                            cr_next[CTL_RECV_FULL] = 1'b1;
                        end
                        if (cl[CTL_RECV_IRQ_EN])
                        begin
                            irq_fire_next = 1'b1;
                            irq_side_next = other;
                            irq_kind_next = IRQ_RECV_READY;
                        end
                    end
                end
            end
            CMD_RECV:
            begin
                if (cl[CTL_ENABLE])
                begin
                    if (f_other.cnt == '0)
                    begin
                        cl_next[CTL_ERROR] = 1'b1;
                    end
                    else
                    begin
                        rd_ok_next       = 1'b1;
                        f_other_next.rp  = (f_other.rp == PTR_LAST) ? '0 : f_other.rp + 1'b1;
                        f_other_next.cnt = f_other.cnt - 1'b1;
                        cl_next          = cl & MASK_RECV_SIDE;
                        cr_next          = cr & MASK_SEND_SIDE;
                        if (f_other_next.cnt == '0)
                        begin
                            cl_next[CTL_RECV_EMPTY] = 1'b1;
                            cr_next[CTL_SEND_EMPTY] = 1'b1;
                        end
                        if (cl[CTL_SEND_IRQ_EN])
                        begin
                            irq_fire_next = 1'b1;
                            irq_side_next = other;
                            irq_kind_next = IRQ_SEND_EMPTY;
                        end
                    end
                end
            end
            CMD_CTRL:
            begin
                if ((cval & MASK_CLEAR_REQ) != '0)
                begin
                    f_me_next = '0;
                    cl_next   = (cl & MASK_KEEP_WRITER) | (cval & MASK_TAKE_VALUE)
                              | 16'h0001;
                    cr_next   = (cr & MASK_KEEP_PEER) | 16'h0100;
                    if (cval[CTL_SEND_IRQ_EN])
                    begin
                        irq_fire_next = 1'b1;
                        irq_side_next = other;
                        irq_kind_next = IRQ_SEND_EMPTY;
                    end
                end
                else
                begin
                    cl_next = cval;
                end
            end
            default:
            begin
                cl_next = cl;
            end
        endcase
    end

    assign rd_en = accept && rd_ok_next;

    // Route the per-side results back to side registers
    always_comb
    begin
        if (me)
        begin
            ctrl1_next = cl_next;
            ctrl0_next = cr_next;
            fifo1_next = f_me_next;
            fifo0_next = f_other_next;
        end
        else
        begin
            ctrl0_next = cl_next;
            ctrl1_next = cr_next;
            fifo0_next = f_me_next;
            fifo1_next = f_other_next;
        end
    end

    // Update state and response valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fifo0_reg     <= '0;
            fifo1_reg     <= '0;
            ctrl0_reg     <= CTL_RESET_VAL;
            ctrl1_reg     <= CTL_RESET_VAL;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                fifo0_reg <= fifo0_next;
                fifo1_reg <= fifo1_next;
                ctrl0_reg <= ctrl0_next;
                ctrl1_reg <= ctrl1_next;
            end
            if (req.ready)
            begin
                rsp_valid_reg <= req.valid;
            end
        end
    end

    // Hold response payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_ok_reg    <= rd_ok_next;
            irq_fire_reg <= irq_fire_next;
            irq_side_reg <= irq_side_next;
            irq_kind_reg <= irq_kind_next;
        end
    end

    // FIFO word storage, side bit on top of the pointer
    mbx_ram #(
        .ADDR_W (PTR_W + 1),
        .DATA_W (32)
    ) u_ram (
        .clk     (clk),
        .wr_en   (accept && wr_en),
        .wr_addr ({me, f_me.wp}),
        .wr_data (req.data.write_data),
        .rd_en   (rd_en),
        .rd_addr ({other, f_other.rp}),
        .rd_data (ram_q)
    );

    // Drive response
    assign rsp.valid              = rsp_valid_reg;
    assign rsp.data.read_data     = rd_ok_reg ? ram_q : '0;
    assign rsp.data.control_side0 = ctrl0_reg;
    assign rsp.data.control_side1 = ctrl1_reg;
    assign rsp.data.irq_fire      = irq_fire_reg;
    assign rsp.data.irq_side      = irq_side_reg;
    assign rsp.data.irq_kind      = irq_kind_reg;

    // Checks
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        (fifo0_reg.cnt <= CNT_FULL) && (fifo1_reg.cnt <= CNT_FULL))
        else $error("fill count beyond FIFO depth");

    a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
        ((fifo0_reg.cnt == '0) || (fifo0_reg.cnt == CNT_FULL)) |->
        (fifo0_reg.rp == fifo0_reg.wp))
        else $error("side 0 pointers disagree with fill count");

    a_accept_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> rsp_valid_reg)
        else $error("accepted item produced no response");

    a_irq_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && !irq_fire_reg) |-> (!irq_side_reg && !irq_kind_reg))
        else $error("interrupt side or kind set without a pulse");

    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && !rsp.ready) |=> ($stable(ctrl0_reg) && $stable(ctrl1_reg)))
        else $error("control words changed while response stalled");

endmodule

[tb/sv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for dual_cpu_mailbox_fifo. Drives bus accesses from both
// sides through the request channel, predicts every response from its own
// copy of the FIFOs, pointers and control words, and compares each field of
// each response in order. Directed accesses come first, then random traffic
// built from send bursts, receive bursts, control writes and noise.
// ----------------------------------------------------------------------------
module testbench;
    import mbx_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          DEPTH       = 16;
    localparam int          CYCLE_LIMIT = 200000;
    localparam int          PRINT_LIMIT = 100;

    localparam logic [15:0] BIT_SEND_IRQ = 16'h1 << CTL_SEND_IRQ_EN;
    localparam logic [15:0] BIT_CLEAR    = 16'h1 << 3;
    localparam logic [15:0] BIT_RECV_IRQ = 16'h1 << CTL_RECV_IRQ_EN;
    localparam logic [15:0] BIT_ERROR    = 16'h1 << CTL_ERROR;
    localparam logic [15:0] BIT_ENABLE   = 16'h1 << CTL_ENABLE;

    logic clk = 1'b0;
    logic rst_n;

    mbx_req_if req_ch ();
    mbx_rsp_if rsp_ch ();

    dual_cpu_mailbox_fifo #(
        .FIFO_DEPTH (DEPTH)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Mirror of the mailbox state
    logic [31:0] fifo_mem [2][DEPTH];
    int          rd_ptr [2]       = '{0, 0};
    int          wr_ptr [2]       = '{0, 0};
    int          fill [2]         = '{0, 0};
    logic [15:0] ctl_word [2]     = '{CTL_RESET_VAL, CTL_RESET_VAL};

    mbx_rsp_t    outcome_q [$];
    int          error_count  = 0;
    int          worked_items = 0;
    int          cycle_count  = 0;
    bit          idling       = 1'b1;

    always #5 clk = ~clk;

    // Apply one access to the mirror and return the response it should give
    function automatic mbx_rsp_t access_outcome(mbx_req_t r);
        mbx_rsp_t    o;
        logic        me;
        logic        peer;
        logic [15:0] mine;
        logic [15:0] theirs;
        logic [15:0] v;
        o      = '0;
        me     = r.side;
        peer   = ~r.side;
        mine   = ctl_word[me];
        theirs = ctl_word[peer];
        v      = r.write_data[15:0];
        case (r.command)
            CMD_SEND:
                if (mine[CTL_ENABLE]) begin
                    if (fill[me] >= DEPTH) begin
                        ctl_word[me][CTL_ERROR] = 1'b1;
                    end else begin
                        mine   &= MASK_SEND_SIDE;
                        theirs &= MASK_RECV_SIDE;
                        fifo_mem[me][wr_ptr[me]] = r.write_data;
                        wr_ptr[me] = (wr_ptr[me] + 1) % DEPTH;
                        fill[me]++;
                        if (fill[me] >= DEPTH) begin
                            mine[CTL_SEND_FULL]   = 1'b1;
                            theirs[CTL_RECV_FULL] = 1'b1;
                        end
                        ctl_word[me]   = mine;
                        ctl_word[peer] = theirs;
                        if (mine[CTL_RECV_IRQ_EN]) begin
                            o.irq_fire = 1'b1;
                            o.irq_side = peer;
                            o.irq_kind = IRQ_RECV_READY;
                        end
                    end
                end
            CMD_RECV:
                if (mine[CTL_ENABLE]) begin
                    if (fill[peer] == 0) begin
                        ctl_word[me][CTL_ERROR] = 1'b1;
                    end else begin
                        mine   &= MASK_RECV_SIDE;
                        theirs &= MASK_SEND_SIDE;
                        o.read_data = fifo_mem[peer][rd_ptr[peer]];
                        rd_ptr[peer] = (rd_ptr[peer] + 1) % DEPTH;
                        fill[peer]--;
                        if (fill[peer] == 0) begin
                            mine[CTL_RECV_EMPTY]   = 1'b1;
                            theirs[CTL_SEND_EMPTY] = 1'b1;
                        end
                        ctl_word[me]   = mine;
                        ctl_word[peer] = theirs;
                        if (mine[CTL_SEND_IRQ_EN]) begin
                            o.irq_fire = 1'b1;
                            o.irq_side = peer;
                            o.irq_kind = IRQ_SEND_EMPTY;
                        end
                    end
                end
            CMD_CTRL:
                if ((v & MASK_CLEAR_REQ) != '0) begin
                    // flush the writer's FIFO and acknowledge the error
                    rd_ptr[me] = 0;
                    wr_ptr[me] = 0;
                    fill[me]   = 0;
                    ctl_word[me] = (mine & MASK_KEEP_WRITER) | (v & MASK_TAKE_VALUE);
                    ctl_word[me][CTL_SEND_EMPTY] = 1'b1;
                    ctl_word[peer] = theirs & MASK_KEEP_PEER;
                    ctl_word[peer][CTL_RECV_EMPTY] = 1'b1;
                    if (v[CTL_SEND_IRQ_EN]) begin
                        o.irq_fire = 1'b1;
                        o.irq_side = peer;
                        o.irq_kind = IRQ_SEND_EMPTY;
                    end
                end else begin
                    ctl_word[me] = v;
                end
            default: ;
        endcase
        o.control_side0 = ctl_word[0];
        o.control_side1 = ctl_word[1];
        return o;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            error_count++;
            if (error_count <= PRINT_LIMIT)
                $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endfunction

    // Record accepted accesses, then check the response taken at this edge
    always @(posedge clk) begin
        mbx_rsp_t want;
        mbx_rsp_t got;
        if (rst_n) begin
            cycle_count++;
            if (req_ch.valid && req_ch.ready) begin
                if (req_ch.data.command == CMD_CTRL ||
                    (req_ch.data.command != CMD_NONE &&
                     ctl_word[req_ch.data.side][CTL_ENABLE]))
                    worked_items++;
                outcome_q.push_back(access_outcome(req_ch.data));
            end
            if (rsp_ch.valid && rsp_ch.ready) begin
                got = rsp_ch.data;
                if (outcome_q.size() == 0) begin
                    error_count++;
                    if (error_count <= PRINT_LIMIT)
                        $display("%0t: response with none expected, expected none, actual %h",
                                 $time, got);
                end else begin
                    want = outcome_q.pop_front();
                    check_field("read_data", want.read_data, got.read_data);
                    check_field("control_side0", 32'(want.control_side0),
                                32'(got.control_side0));
                    check_field("control_side1", 32'(want.control_side1),
                                32'(got.control_side1));
                    check_field("irq_fire", 32'(want.irq_fire), 32'(got.irq_fire));
                    check_field("irq_side", 32'(want.irq_side), 32'(got.irq_side));
                    check_field("irq_kind", 32'(want.irq_kind), 32'(got.irq_kind));
                end
            end
        end
    end

    // Stall the response side in random bursts while idling is set
    initial begin
        int n;
        rsp_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (idling && $urandom_range(0, 3) == 0) begin
                n = $urandom_range(1, 15);
                rsp_ch.ready <= 1'b0;
            end else begin
                n = $urandom_range(1, 20);
                rsp_ch.ready <= 1'b1;
            end
            repeat (n - 1) @(negedge clk);
        end
    end

    // Stop a hung run
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
            @(posedge clk);
        $display("testbench: done, errors");
        $finish;
    end

    // Present one access and hold it until taken, with an optional gap first
    task automatic send_item(input mbx_cmd_t cmd, input logic s, input logic [31:0] d);
        int gap;
        @(negedge clk);
        if (idling && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 15);
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= '{command: cmd, side: s, write_data: d};
        do begin
            @(posedge clk);
        end while (!req_ch.ready);
    endtask

    // Hold off new accesses until every response is back
    task automatic drain_outcomes();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (outcome_q.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 7))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Well-formed control value: enabled, random irq enables, sometimes a flush
    function automatic logic [15:0] ctrl_value();
        logic [15:0] v;
        v = BIT_ENABLE;
        if ($urandom_range(0, 1)) v |= BIT_SEND_IRQ;
        if ($urandom_range(0, 1)) v |= BIT_RECV_IRQ;
        case ($urandom_range(0, 5))
            0:       v |= BIT_CLEAR;
            1:       v |= BIT_ERROR;
            2:       v |= BIT_CLEAR | BIT_ERROR;
            default: ;
        endcase
        return v;
    endfunction

    function automatic logic [15:0] upper_half();
        return 16'($urandom);
    endfunction

    // Accesses while both sides are still disabled, and the unused command
    task automatic test_disabled_access();
        send_item(CMD_SEND, 1'b0, 32'hFFFF_FFFF);
        send_item(CMD_RECV, 1'b1, 32'h0000_0000);
        send_item(CMD_NONE, 1'b1, $urandom);
        send_item(CMD_NONE, 1'b0, 32'hFFFF_FFFF);
    endtask

    // Enable both sides and move words in both directions, with underflow
    task automatic test_basic_transfer();
        send_item(CMD_CTRL, 1'b0, {upper_half(), BIT_ENABLE | BIT_RECV_IRQ});
        send_item(CMD_CTRL, 1'b1, {upper_half(), BIT_ENABLE | BIT_SEND_IRQ});
        send_item(CMD_RECV, 1'b1, $urandom);
        send_item(CMD_SEND, 1'b0, 32'hFFFF_FFFF);
        send_item(CMD_SEND, 1'b0, 32'h0000_0000);
        send_item(CMD_RECV, 1'b1, 32'hFFFF_FFFF);
        send_item(CMD_RECV, 1'b0, $urandom);
        send_item(CMD_RECV, 1'b1, 32'h0000_0000);
        send_item(CMD_SEND, 1'b1, 32'h8000_0001);
        send_item(CMD_RECV, 1'b0, $urandom);
    endtask

    // Flush through the clear bit and through the error bit, then raw writes
    task automatic test_clear_and_ack();
        send_item(CMD_SEND, 1'b1, 32'hA5A5_A5A5);
        send_item(CMD_CTRL, 1'b1, {upper_half(), BIT_ENABLE | BIT_CLEAR | BIT_SEND_IRQ});
        send_item(CMD_RECV, 1'b0, $urandom);
        send_item(CMD_CTRL, 1'b0, {upper_half(), BIT_ENABLE | BIT_ERROR | BIT_RECV_IRQ});
        send_item(CMD_CTRL, 1'b0, 32'hFFFF_FFFF);
        send_item(CMD_CTRL, 1'b1, {upper_half(), 16'h3B32});
        send_item(CMD_CTRL, 1'b1, 32'h0000_0000);
        send_item(CMD_CTRL, 1'b1, {upper_half(), BIT_ENABLE});
    endtask

    // Random traffic until target accesses have taken effect
    task automatic test_random_traffic(input int target);
        int   stop_at;
        int   len;
        logic s;
        stop_at = worked_items + target;
        while (worked_items < stop_at) begin
            s   = 1'($urandom_range(0, 1));
            len = $urandom_range(1, DEPTH + 2);
            case ($urandom_range(0, 9))
                0, 1, 2, 3:
                    repeat (len) send_item(CMD_SEND, s, pick_word());
                4, 5, 6:
                    repeat (len) send_item(CMD_RECV, s, pick_word());
                7:
                    repeat (len)
                        send_item(mbx_cmd_t'($urandom_range(0, 1)),
                                  1'($urandom_range(0, 1)), pick_word());
                8:
                    send_item(CMD_CTRL, s, {upper_half(), ctrl_value()});
                default:
                    case ($urandom_range(0, 2))
                        0:       send_item(CMD_NONE, s, pick_word());
                        1:       send_item(CMD_CTRL, s, $urandom);
                        default: send_item(CMD_CTRL, s, {upper_half(), BIT_ENABLE});
                    endcase
            endcase
        end
    endtask

    initial begin
        rst_n        = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.data  = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_disabled_access();
        test_basic_transfer();
        test_clear_and_ack();
        drain_outcomes();

        test_random_traffic(1000);
        drain_outcomes();
        idling = 1'b0;
        test_random_traffic(350);
        drain_outcomes();

        repeat (10) @(posedge clk);
        if (error_count == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule

[dual_cpu_mailbox_fifo.f]
hdl/mbx_pkg.sv
hdl/mbx_if.sv
hdl/mbx_ram.sv
hdl/dual_cpu_mailbox_fifo.sv
tb/sv/testbench.sv
